>>> design/lbs_pkg.sv
`default_nettype none

package lbs_pkg;

  // Default size of the bone matrix table.
  localparam int MaxBonesDefault = 64;
  // Words in one 3x4 row-major affine matrix.
  localparam int MatWords = 12;
  // Width used to compare a bone index against the bone count (count up to 511).
  localparam int BoneCmpW = 9;

  // Stream payload widths.
  localparam int InDataW  = 160;
  localparam int OutDataW = 96;

  // Matrix layout: the translation column and the last column that is multiplied.
  localparam logic [1:0] TransCol   = 2'd3;
  localparam logic [1:0] LastMulCol = 2'd2;
  localparam logic [1:0] LastRow    = 2'd2;

  // Item kinds carried in the input tuser bit.
  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_BLEND = 1'b1
  } cmd_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       mem_we;
    logic       rd_en;
    logic [1:0] rd_row;
    logic [1:0] rd_col;
    logic       emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_e cmd;
    logic last;
    logic bone_ok;
    logic row_done;
    logic out_full;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> design/linear_blend_vertex_skinning.sv
`default_nettype none

// Linear blend skinning engine. A load transaction (tuser = 0) writes one
// signed Q16.16 word of a bone's 3x4 row-major world matrix. A contribution
// transaction (tuser = 1) transforms its Q16.16 offset by the bone's matrix,
// scales it by the Q1.15 weight and adds it to a running position. Its steps
// are set by the single shared 32x33 multiplier and the single read port of
// the matrix table:
// - accept, then dispatch;
// - the table reads, row by row: for each of the first two rows the
//   translation, the three multiplied words and a gap for the weight
//   product, and for the last row the same without the gap;
// - pipeline drain.
// A contribution with tlast set then emits the saturated position and clears
// the sums. It waits in that state while the output register still holds a
// result that has not been taken. Otherwise the result waits in the output
// register while the next transaction is taken.
// A contribution from a bone at or above MAX_BONES adds nothing but still
// honors tlast. Matrix words must be loaded before they are used.

module linear_blend_vertex_skinning #(
  parameter int MAX_BONES = lbs_pkg::MaxBonesDefault
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  // Fields from bit 0 up: bone_index, matrix_entry, matrix_value, weight,
  // offset_x, offset_y, offset_z, zero fill.
  input  wire [lbs_pkg::InDataW-1:0]   s_axis_tdata,
  // command
  input  wire                          s_axis_tuser,
  // last_bone
  input  wire                          s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  // Fields from bit 0 up: pos_x, pos_y, pos_z.
  output logic [lbs_pkg::OutDataW-1:0] m_axis_tdata,
  // saturated
  output logic                         m_axis_tuser
);

  lbs_pkg::ctrl_cmd_t cmd;
  lbs_pkg::dp_sts_t   sts;

  // Sequencer.
  lbs_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  // Matrix table, multiplier, accumulators and output register.
  lbs_datapath #(
    .MAX_BONES (MAX_BONES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

>>> design/lbs_ctrl.sv
`default_nettype none

module lbs_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 s_axis_tvalid,
  output logic                s_axis_tready,
  input  lbs_pkg::dp_sts_t    sts_i,
  output lbs_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_DISPATCH = 5'b00010,
    ST_READ     = 5'b00100,
    ST_DRAIN    = 5'b01000,
    ST_EMIT     = 5'b10000
  } state_e;

  localparam logic [2:0] PhaseGap = 3'd4;
  localparam logic [2:0] PhaseEnd = 3'd3;

  state_e     state_q, state_d;
  logic [1:0] row_q, row_d;
  logic [2:0] phase_q, phase_d;

  // Next-state and command logic. The first two matrix rows take their read
  // slots in this order: translation first, then the three multiplied columns,
  // then one gap so the weight product can use the multiplier. The last row
  // skips the gap and the controller waits in the drain state instead.
  always_comb begin
    state_d       = state_q;
    row_d         = row_q;
    phase_d       = phase_q;
    s_axis_tready = 1'b0;
    cmd_o         = '0;
    cmd_o.rd_row  = row_q;
    cmd_o.rd_col  = phase_q[1:0] - 2'd1;

    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts_i.cmd == lbs_pkg::CMD_LOAD) begin
          cmd_o.mem_we = 1'b1;
          state_d      = ST_IDLE;
        end else if (sts_i.bone_ok) begin
          row_d   = 2'd0;
          phase_d = 3'd0;
          state_d = ST_READ;
        end else if (sts_i.last) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        cmd_o.rd_en = (phase_q != PhaseGap);
        if (phase_q == PhaseGap) begin
          phase_d = 3'd0;
          row_d   = row_q + 2'd1;
        end else if (row_q == lbs_pkg::LastRow && phase_q == PhaseEnd) begin
          state_d = ST_DRAIN;
        end else begin
          phase_d = phase_q + 3'd1;
        end
      end
      ST_DRAIN: begin
        if (sts_i.row_done) begin
          state_d = sts_i.last ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!sts_i.out_full) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= 2'd0;
      phase_q <= 3'd0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      phase_q <= phase_d;
    end
  end

  // The last row's sum update only arrives while the controller waits for it.
  a_row_done_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.row_done |-> state_q == ST_DRAIN)
    else $error("row completion outside the drain wait");

  // Reads are only issued while the controller walks the matrix.
  a_read_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |-> (state_q == ST_READ && row_q <= lbs_pkg::LastRow))
    else $error("matrix read outside the row walk");

endmodule

`default_nettype wire

>>> design/lbs_datapath.sv
`default_nettype none

module lbs_datapath #(
  parameter int MAX_BONES = lbs_pkg::MaxBonesDefault
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  lbs_pkg::ctrl_cmd_t           cmd_i,
  output lbs_pkg::dp_sts_t             sts_o,
  // Fields from bit 0 up: bone_index, matrix_entry, matrix_value, weight,
  // offset_x, offset_y, offset_z, zero fill.
  input  wire [lbs_pkg::InDataW-1:0]   s_axis_tdata,
  // command
  input  wire                          s_axis_tuser,
  // last_bone
  input  wire                          s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  // Fields from bit 0 up: pos_x, pos_y, pos_z.
  output logic [lbs_pkg::OutDataW-1:0] m_axis_tdata,
  // saturated
  output logic                         m_axis_tuser
);

  localparam int Depth = MAX_BONES * lbs_pkg::MatWords;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

  localparam logic signed [31:0] Max32 = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Min32 = 32'sh8000_0000;
  localparam logic signed [63:0] Max64 = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] Min64 = 64'sh8000_0000_0000_0000;

  // Captured transaction.
  lbs_pkg::cmd_e      cmd_q;
  logic               last_q;
  logic [5:0]         bone_q;
  logic [3:0]         entry_q;
  logic signed [31:0] mval_q;
  logic [15:0]        weight_q;
  logic signed [31:0] off_q [3];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q    <= lbs_pkg::cmd_e'(s_axis_tuser);
      last_q   <= s_axis_tlast;
      bone_q   <= s_axis_tdata[5:0];
      entry_q  <= s_axis_tdata[9:6];
      mval_q   <= s_axis_tdata[41:10];
      weight_q <= s_axis_tdata[57:42];
      off_q[0] <= s_axis_tdata[89:58];
      off_q[1] <= s_axis_tdata[121:90];
      off_q[2] <= s_axis_tdata[153:122];
    end
  end

  logic bone_ok, entry_ok;
  assign bone_ok  = ({3'b000, bone_q} < lbs_pkg::BoneCmpW'(MAX_BONES));
  assign entry_ok = (entry_q < 4'(lbs_pkg::MatWords));

  // Table addressing: bone * 12 + word.
  logic [13:0]   base;
  logic [AW-1:0] wr_addr, rd_addr;
  assign base    = ({8'b0, bone_q} << 3) + ({8'b0, bone_q} << 2);
  assign wr_addr = AW'(base + {10'b0, entry_q});
  assign rd_addr = AW'(base + {10'b0, cmd_i.rd_row, cmd_i.rd_col});

  // Bone matrix table, one write or one read per cycle.
  logic signed [31:0] mem [Depth];
  logic signed [31:0] mem_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we && bone_ok && entry_ok) begin
      mem[wr_addr] <= mval_q;
    end
    if (cmd_i.rd_en) begin
      mem_rd_q <= mem[rd_addr];
    end
  end

  // Pipeline tags: read data, product, weight step, sum update.
  logic       v1_q, v2m_q, wv_q, v2w_q;
  logic [1:0] col1_q, row1_q, col2_q, row2_q, wrow_q, row4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2m_q <= 1'b0;
      wv_q  <= 1'b0;
      v2w_q <= 1'b0;
    end else begin
      v1_q  <= cmd_i.rd_en;
      v2m_q <= v1_q && (col1_q != lbs_pkg::TransCol);
      wv_q  <= v2m_q && (col2_q == lbs_pkg::LastMulCol);
      v2w_q <= wv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    col1_q <= cmd_i.rd_col;
    row1_q <= cmd_i.rd_row;
    col2_q <= col1_q;
    row2_q <= row1_q;
    wrow_q <= row2_q;
    row4_q <= wrow_q;
  end

  // Row accumulator and its clamp to a 32-bit world coordinate.
  logic signed [51:0] acc_q;
  logic signed [31:0] world;
  logic               world_clamp;

  always_comb begin
    world_clamp = !((&acc_q[51:31]) || !(|acc_q[51:31]));
    if (world_clamp) begin
      world = acc_q[51] ? Min32 : Max32;
    end else begin
      world = acc_q[31:0];
    end
  end

  // Shared multiplier: matrix word times offset, or world coordinate times weight.
  logic signed [31:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [64:0] prod_q;

  always_comb begin
    if (wv_q) begin
      mul_a = world;
      mul_b = {17'b0, weight_q};
    end else begin
      mul_a = mem_rd_q;
      case (col1_q)
        2'd0:    mul_b = 33'(off_q[0]);
        2'd1:    mul_b = 33'(off_q[1]);
        default: mul_b = 33'(off_q[2]);
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wv_q || (v1_q && col1_q != lbs_pkg::TransCol)) begin
      prod_q <= 65'(mul_a) * 65'(mul_b);
    end
  end

  // Rounded terms: Q32.32 to Q16.16, and the weighted product back to Q16.16.
  logic signed [64:0] rnd16, rnd15;
  logic signed [48:0] term16;
  logic signed [33:0] term15;
  assign rnd16  = prod_q + 65'sd32768;
  assign rnd15  = prod_q + 65'sd16384;
  assign term16 = rnd16[64:16];
  assign term15 = rnd15[48:15];

  // Accumulator starts at the translation and gathers the rounded products.
  always_ff @(posedge clk_i) begin
    if (v1_q && col1_q == lbs_pkg::TransCol) begin
      acc_q <= 52'(mem_rd_q);
    end else if (v2m_q) begin
      acc_q <= acc_q + 52'(term16);
    end
  end

  // Saturating add of the weighted term into the selected position sum.
  logic signed [63:0] sum_q [3];
  logic signed [63:0] sum_sel, sum_new;
  logic signed [64:0] sum_wide;
  logic               add_sat;

  always_comb begin
    case (row4_q)
      2'd0:    sum_sel = sum_q[0];
      2'd1:    sum_sel = sum_q[1];
      default: sum_sel = sum_q[2];
    endcase
    sum_wide = 65'(sum_sel) + 65'(term15);
    add_sat  = (sum_wide[64] != sum_wide[63]);
    if (add_sat) begin
      sum_new = sum_wide[64] ? Min64 : Max64;
    end else begin
      sum_new = sum_wide[63:0];
    end
  end

  // Emission clamps of the three sums.
  logic signed [31:0] pos [3];
  logic [2:0]         pos_clamp;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos_clamp[i] = !((&sum_q[i][63:31]) || !(|sum_q[i][63:31]));
      if (pos_clamp[i]) begin
        pos[i] = sum_q[i][63] ? Min32 : Max32;
      end else begin
        pos[i] = sum_q[i][31:0];
      end
    end
  end

  // Position sums and the sticky saturation flag for the current vertex.
  logic sticky_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q[0] <= '0;
      sum_q[1] <= '0;
      sum_q[2] <= '0;
      sticky_q <= 1'b0;
    end else if (cmd_i.emit) begin
      sum_q[0] <= '0;
      sum_q[1] <= '0;
      sum_q[2] <= '0;
      sticky_q <= 1'b0;
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (v2w_q && row4_q == 2'(i)) begin
          sum_q[i] <= sum_new;
        end
      end
      sticky_q <= sticky_q || (wv_q && world_clamp) || (v2w_q && add_sat);
    end
  end

  // Output register; a result waits here while the next transaction is taken.
  logic m_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      m_axis_tdata <= {pos[2], pos[1], pos[0]};
      m_axis_tuser <= sticky_q || (|pos_clamp);
    end
  end

  assign m_axis_tvalid = m_valid_q;

  // Status back to the controller.
  always_comb begin
    sts_o          = '0;
    sts_o.cmd      = cmd_q;
    sts_o.last     = last_q;
    sts_o.bone_ok  = bone_ok;
    sts_o.row_done = v2w_q && (row4_q == lbs_pkg::LastRow);
    sts_o.out_full = m_valid_q && !m_axis_tready;
  end

  // The product register holds one kind of product at a time.
  a_prod_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(v2m_q && v2w_q))
    else $error("matrix and weight products in flight together");

  // The weight step never competes with a matrix multiply for the multiplier.
  a_mul_no_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wv_q && v1_q && col1_q != lbs_pkg::TransCol))
    else $error("multiplier claimed twice");

  // A result is never written over one that has not been taken.
  a_emit_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !(m_valid_q && !m_axis_tready))
    else $error("emission into a full output register");

endmodule

`default_nettype wire

>>> tb/sv/tb_linear_blend_vertex_skinning.sv
`default_nettype none

module tb_linear_blend_vertex_skinning;
  import lbs_pkg::*;

  localparam int     NumBones   = MaxBonesDefault;
  localparam int     HoldCycles = 500;
  localparam longint S32Max     = 64'sd2147483647;
  localparam longint S32Min     = -64'sd2147483648;
  localparam longint S64Max     = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint S64Min     = 64'sh8000_0000_0000_0000;

  // One input transaction, split into its fields.
  typedef struct packed {
    cmd_e             cmd;
    logic             last;
    logic [2:0][31:0] offs;
    logic [15:0]      weight;
    logic [31:0]      mval;
    logic [3:0]       entry;
    logic [5:0]       bone;
  } blend_item_t;

  // One skinned vertex position.
  typedef struct packed {
    logic        sat;
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } skin_pos_t;

  // Tracks the matrix table and running sums, and holds the positions still due.
  class skin_scoreboard;
    int        bone_mat [NumBones][MatWords];
    longint    pos_acc [3];
    bit        clamp_seen;
    skin_pos_t expected_positions [$];
    int        mismatches;

    function int clamp_word(longint v);
      if (v > S32Max) begin
        clamp_seen = 1'b1;
        return int'(S32Max);
      end
      if (v < S32Min) begin
        clamp_seen = 1'b1;
        return int'(S32Min);
      end
      return int'(v);
    endfunction

    function longint add_saturating(longint a, longint b);
      if (b > 0 && a > S64Max - b) begin
        clamp_seen = 1'b1;
        return S64Max;
      end
      if (b < 0 && a < S64Min - b) begin
        clamp_seen = 1'b1;
        return S64Min;
      end
      return a + b;
    endfunction

    function int pending();
      return expected_positions.size();
    endfunction

    // Applies one accepted transaction and queues the position it emits, if any.
    function void note_item(blend_item_t it);
      longint    row_sum;
      longint    term;
      longint    wt;
      int        world;
      int        r;
      int        c;
      skin_pos_t pos;
      if (it.cmd == CMD_LOAD) begin
        if (it.entry < MatWords) bone_mat[it.bone][it.entry] = it.mval;
        return;
      end
      wt = longint'({48'd0, it.weight});
      if (it.bone < NumBones) begin
        for (r = 0; r < 3; r++) begin
          row_sum = longint'(bone_mat[it.bone][r * 4 + TransCol]);
          for (c = 0; c < 3; c++) begin
            row_sum += (longint'(bone_mat[it.bone][r * 4 + c]) *
                        longint'(signed'(it.offs[c])) + 32768) >>> 16;
          end
          world = clamp_word(row_sum);
          term = (longint'(world) * wt + 16384) >>> 15;
          pos_acc[r] = add_saturating(pos_acc[r], term);
        end
      end
      if (!it.last) return;
      pos.x = clamp_word(pos_acc[0]);
      pos.y = clamp_word(pos_acc[1]);
      pos.z = clamp_word(pos_acc[2]);
      pos.sat = clamp_seen;
      pos_acc = '{default: 0};
      clamp_seen = 1'b0;
      expected_positions.push_back(pos);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    // Compares one accepted output transaction with the oldest expected position.
    task check_position(logic [OutDataW-1:0] data, logic sat);
      skin_pos_t want;
      if (expected_positions.size() == 0) begin
        report($sformatf("unexpected position %h sat %b", data, sat));
        return;
      end
      want = expected_positions.pop_front();
      if (data[31:0] !== want.x)
        report($sformatf("pos_x got %h want %h", data[31:0], want.x));
      if (data[63:32] !== want.y)
        report($sformatf("pos_y got %h want %h", data[63:32], want.y));
      if (data[95:64] !== want.z)
        report($sformatf("pos_z got %h want %h", data[95:64], want.z));
      if (sat !== want.sat)
        report($sformatf("saturated got %b want %b", sat, want.sat));
    endtask
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  skin_scoreboard skin_sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int          holds_asked   = 0;
  int          holds_done;
  int          hold_left;
  int          items_sent    = 0;
  bit          word_loaded [NumBones][MatWords];

  linear_blend_vertex_skinning u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  // Receiver: random stalls, plus a long hold-off whenever one is asked for.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left <= 0;
      holds_done <= 0;
    end else if (holds_done != holds_asked) begin
      holds_done <= holds_asked;
      hold_left <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watch both sides; values read here are the ones sampled at this edge.
  always @(posedge clk_i) begin
    blend_item_t seen;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      seen.cmd     = cmd_e'(s_axis_tuser);
      seen.last    = s_axis_tlast;
      seen.bone    = s_axis_tdata[5:0];
      seen.entry   = s_axis_tdata[9:6];
      seen.mval    = s_axis_tdata[41:10];
      seen.weight  = s_axis_tdata[57:42];
      seen.offs[0] = s_axis_tdata[89:58];
      seen.offs[1] = s_axis_tdata[121:90];
      seen.offs[2] = s_axis_tdata[153:122];
      skin_sb.note_item(seen);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      skin_sb.check_position(m_axis_tdata, m_axis_tuser);
  end

  // Offers one transaction after a random idle gap and waits for its handshake.
  task automatic send_item(blend_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.cmd;
    s_axis_tlast  <= it.last;
    s_axis_tdata  <= {6'd0, it.offs[2], it.offs[1], it.offs[0], it.weight, it.mval,
                      it.entry, it.bone};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (!(it.cmd == CMD_LOAD && it.entry >= MatWords)) items_sent++;
  endtask

  task automatic send_load(int bone, int entry, logic [31:0] value, logic last);
    blend_item_t it;
    it = '0;
    it.cmd   = CMD_LOAD;
    it.bone  = bone[5:0];
    it.entry = entry[3:0];
    it.mval  = value;
    it.last  = last;
    if (entry < MatWords) word_loaded[bone][entry] = 1'b1;
    send_item(it);
  endtask

  task automatic send_blend(int bone, logic [15:0] weight, logic [31:0] x, logic [31:0] y,
                            logic [31:0] z, logic last);
    blend_item_t it;
    it = '0;
    it.cmd     = CMD_BLEND;
    it.bone    = bone[5:0];
    it.weight  = weight;
    it.offs[0] = x;
    it.offs[1] = y;
    it.offs[2] = z;
    it.last    = last;
    send_item(it);
  endtask

  // Mostly plausible transforms, sometimes any 32-bit word.
  function automatic logic [31:0] rand_matrix_word(int entry);
    if ($urandom_range(99) < 15) return $urandom();
    if (entry % 4 == TransCol) return $urandom_range(32'h0200_0000) - 32'h0100_0000;
    return $urandom_range(32'h0004_0000) - 32'h0002_0000;
  endfunction

  function automatic logic [31:0] rand_offset();
    if ($urandom_range(99) < 15) return $urandom();
    return $urandom_range(32'h0080_0000) - 32'h0040_0000;
  endfunction

  function automatic logic [15:0] rand_weight();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return 16'd0;
    if (pick < 20) return 16'($urandom_range(16'hFFFF));
    return 16'($urandom_range(32768));
  endfunction

  // Loads a whole matrix for one bone, words in shuffled order.
  task automatic send_matrix(int bone);
    int order [MatWords];
    int pick;
    int tmp;
    for (int i = 0; i < MatWords; i++) order[i] = i;
    for (int i = MatWords - 1; i > 0; i--) begin
      pick = $urandom_range(i);
      tmp = order[i];
      order[i] = order[pick];
      order[pick] = tmp;
    end
    for (int i = 0; i < MatWords; i++)
      send_load(bone, order[i], rand_matrix_word(order[i]), $urandom_range(9) == 0);
  endtask

  // One vertex: one to four contributions from fully loaded bones, tlast on the final one.
  task automatic send_vertex();
    int ready [$];
    int count;
    int bone;
    bit whole;
    for (int b = 0; b < NumBones; b++) begin
      whole = 1'b1;
      for (int e = 0; e < MatWords; e++) whole &= word_loaded[b][e];
      if (whole) ready.push_back(b);
    end
    if (ready.size() == 0) begin
      bone = $urandom_range(NumBones - 1);
      send_matrix(bone);
      ready.push_back(bone);
    end
    count = $urandom_range(1, 4);
    for (int i = 0; i < count; i++)
      send_blend(ready[$urandom_range(ready.size() - 1)], rand_weight(), rand_offset(),
                 rand_offset(), rand_offset(), i == count - 1);
  endtask

  // Sender stops and waits until every expected position has been taken.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (skin_sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(int unsigned src_idle, int unsigned dst_stall, int target,
                           bit with_hold);
    int          stop_at;
    int unsigned pick;
    send_idle_pct = src_idle;
    stall_pct = dst_stall;
    if (with_hold) holds_asked++;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        send_matrix($urandom_range(NumBones - 1));
      end else if (pick < 90) begin
        send_vertex();
      end else begin
        send_load($urandom_range(NumBones - 1), $urandom_range(15), $urandom(),
                  1'($urandom_range(1)));
      end
      if ($urandom_range(99) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Bone 0 gets extreme words: even entries at the top of the range, odd at the bottom.
    for (int e = 0; e < MatWords; e++)
      send_load(0, e, (e % 2 == 0) ? 32'h7FFF_FFFF : 32'h8000_0000, 1'b0);
    // Entries past the matrix are dropped, and tlast on a load emits nothing.
    send_load(0, 15, 32'hFFFF_FFFF, 1'b1);
    send_load(NumBones - 1, 12, 32'h5555_AAAA, 1'b0);
    // Zero weight, unity weight and the largest weight, with extreme offsets.
    send_blend(0, 16'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_blend(0, 16'd32768, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_blend(0, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    // Zero weight alone gives the origin without a clamp.
    send_blend(0, 16'd0, 32'h0, 32'h0, 32'h0, 1'b1);
    // Smallest weight on the translation column only.
    send_blend(0, 16'd1, 32'h0, 32'h0, 32'h0, 1'b1);
    wait_drained();

    run_phase(0, 0, 380, 1'b1);
    run_phase(78, 0, 380, 1'b0);
    run_phase(0, 78, 380, 1'b0);
    run_phase(14, 14, 380, 1'b0);

    repeat (40) @(posedge clk_i);
    if (skin_sb.pending() != 0)
      skin_sb.report($sformatf("%0d expected positions never arrived", skin_sb.pending()));
    if (skin_sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
